### hw/rtl/sccmb_pkg.sv
// shared types and constants of the supercap charge monitor and blinker
package sccmb_pkg;

  localparam int ADC_BITS_DEF   = 10;
  localparam int TIMER_BITS_DEF = 12;

  localparam int LEVEL_W    = 11;
  localparam int TICK_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int BUF_W      = 2;
  localparam int IND_W      = 3;
  localparam int TOG_W      = 3;
  localparam int SCALE_W    = 11;

  localparam logic [SCALE_W-1:0] MV_SCALE = 11'd1595;

  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PAUSE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AFTER_SLEEP  = 3'd6;

  localparam logic [BUF_W-1:0] BUF_START  = 2'd0;
  localparam logic [BUF_W-1:0] BUF_EMPTY  = 2'd1;
  localparam logic [BUF_W-1:0] BUF_DISCH  = 2'd2;
  localparam logic [BUF_W-1:0] BUF_CHARGE = 2'd3;

  localparam logic [IND_W-1:0] IND_OFF   = 3'd0;
  localparam logic [IND_W-1:0] IND_RUN   = 3'd1;
  localparam logic [IND_W-1:0] IND_EMPTY = 3'd2;
  localparam logic [IND_W-1:0] IND_UP    = 3'd3;
  localparam logic [IND_W-1:0] IND_DOWN  = 3'd4;
  localparam logic [IND_W-1:0] IND_FULL  = 3'd5;

  localparam logic [TOG_W-1:0] TOG_EMPTY = 3'd1;
  localparam logic [TOG_W-1:0] TOG_UP    = 3'd3;
  localparam logic [TOG_W-1:0] TOG_DOWN  = 3'd5;
  localparam logic [TOG_W-1:0] TOG_FULL  = 3'd7;

  localparam logic [LEVEL_W-1:0] EMPTY_LEVEL_RST  = 11'd1000;
  localparam logic [LEVEL_W-1:0] CHARGE_LEVEL_RST = 11'd1200;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL_RST   = 11'd1500;
  localparam logic [TICK_W-1:0]  BLINK_STEP_RST   = 12'd200;
  localparam logic [TICK_W-1:0]  BLINK_PAUSE_RST  = 12'd1000;
  localparam logic [TICK_W-1:0]  SAMPLE_PER_RST   = 12'd250;
  localparam logic [TICK_W-1:0]  AFTER_SLEEP_RST  = 12'd1;
  localparam int                 SAMPLE_TMR_RST   = 100;

  typedef struct packed {
    logic [BUF_W-1:0] buf_nxt;
    logic             usb_nxt;
    logic             req;
    logic [IND_W-1:0] req_mode;
    logic             sleep;
  } sample_res_t;

endpackage

### hw/rtl/sccmb_sample.sv
// sample step: millivolt scaling and buffer state machine with hysteresis
module sccmb_sample #(
  parameter int ADC_BITS = sccmb_pkg::ADC_BITS_DEF
) (
  input  logic [ADC_BITS-1:0]          adc_code,
  input  logic [sccmb_pkg::BUF_W-1:0]   buf_state,
  input  logic                         usb_level,
  input  logic                         idle,
  input  logic [sccmb_pkg::LEVEL_W-1:0] empty_level,
  input  logic [sccmb_pkg::LEVEL_W-1:0] charge_level,
  input  logic [sccmb_pkg::LEVEL_W-1:0] full_level,
  output sccmb_pkg::sample_res_t       res
);
  import sccmb_pkg::*;

  localparam int PROD_W = ADC_BITS + SCALE_W;
  localparam int MV_W   = ADC_BITS + 1;
  localparam int CMP_W  = (MV_W > LEVEL_W) ? MV_W : LEVEL_W;

  logic [PROD_W-1:0] prod;
  logic [CMP_W-1:0]  mv;
  logic              below_empty;
  logic              below_charge;
  logic              above_charge;
  logic              above_full;

  assign prod         = PROD_W'(adc_code) * PROD_W'(MV_SCALE);
  assign mv           = CMP_W'(prod[PROD_W-1:SCALE_W-1]);
  assign below_empty  = mv < CMP_W'(empty_level);
  assign below_charge = mv < CMP_W'(charge_level);
  assign above_charge = mv > CMP_W'(charge_level);
  assign above_full   = mv > CMP_W'(full_level);

  always_comb begin
    res.buf_nxt  = buf_state;
    res.usb_nxt  = usb_level;
    res.req      = 1'b0;
    res.req_mode = IND_OFF;
    res.sleep    = 1'b0;
    case (buf_state)
      BUF_START: begin
        if (below_empty) begin
          res.buf_nxt  = BUF_EMPTY;
          res.req      = 1'b1;
          res.req_mode = IND_EMPTY;
        end else if (above_full) begin
          res.buf_nxt  = BUF_DISCH;
          res.req      = 1'b1;
          res.req_mode = IND_FULL;
          res.usb_nxt  = 1'b1;
        end else if (idle) begin
          res.buf_nxt  = BUF_DISCH;
          res.req      = 1'b1;
          res.req_mode = IND_UP;
          res.usb_nxt  = 1'b1;
        end
      end
      BUF_DISCH: begin
        if (below_charge) begin
          res.buf_nxt  = BUF_CHARGE;
          res.req      = 1'b1;
          res.req_mode = IND_UP;
          res.usb_nxt  = 1'b0;
        end else if (idle) begin
          res.sleep = 1'b1;
        end
      end
      BUF_CHARGE: begin
        if (above_full) begin
          res.buf_nxt  = BUF_DISCH;
          res.req      = 1'b1;
          res.req_mode = IND_DOWN;
          res.usb_nxt  = 1'b1;
        end else if (below_empty) begin
          res.buf_nxt  = BUF_EMPTY;
          res.req      = 1'b1;
          res.req_mode = IND_EMPTY;
        end else if (idle) begin
          res.sleep = 1'b1;
        end
      end
      default: begin
        if (above_charge) begin
          res.buf_nxt  = BUF_DISCH;
          res.req      = 1'b1;
          res.req_mode = IND_UP;
        end else if (idle) begin
          res.sleep = 1'b1;
        end
      end
    endcase
  end

endmodule

### hw/rtl/supercap_charge_monitor_blinker.sv
// Supercap charge monitor and blinker. Each input beat is one millisecond tick
// carrying the latest ADC code and yields one result beat, registered in the cycle after
// acceptance. A beat can be accepted in every cycle: the whole tick (timer
// countdown, sample step and blink step) is one pass of logic from the state
// registers into the state and result registers, so the rate is one beat per
// cycle, and the input stalls only while a result is held by a stalled output.
// Configuration writes take effect at the next tick.
module supercap_charge_monitor_blinker #(
  parameter int ADC_BITS   = sccmb_pkg::ADC_BITS_DEF,
  parameter int TIMER_BITS = sccmb_pkg::TIMER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ADC_BITS-1:0]              in_adc_code,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_led_on,
  output logic                             out_usb_on,
  output logic                             out_sleep_request,
  output logic [sccmb_pkg::BUF_W-1:0]      out_buffer_mode,
  input  logic                             cfg_wr_en,
  input  logic [sccmb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sccmb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sccmb_pkg::*;

  localparam int TW = TIMER_BITS;

  function automatic logic [TW-1:0] reload_of(input logic [TICK_W-1:0] v);
    logic [TW-1:0] t;
    t = TW'(v);
    return (t == '0) ? TW'(1) : t;
  endfunction

  logic [LEVEL_W-1:0] empty_level_r, charge_level_r, full_level_r;
  logic [TICK_W-1:0]  blink_step_r, blink_pause_r, sample_per_r, after_sleep_r;

  logic [BUF_W-1:0] buf_state_r, buf_state_nxt;
  logic [IND_W-1:0] ind_mode_r, ind_mode_nxt;
  logic [TOG_W-1:0] toggles_r, toggles_nxt;
  logic             led_r, led_nxt;
  logic             usb_r, usb_nxt;
  logic [TW-1:0]    blink_tmr_r, blink_tmr_nxt;
  logic [TW-1:0]    sample_tmr_r, sample_tmr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             sleep_r, sleep_nxt;

  logic        accept;
  logic        sample_due;
  logic        blink_due;
  logic        idle;
  logic [IND_W-1:0] ind_mid;
  logic [IND_W-1:0] ind_blk;
  logic [TOG_W-1:0] tog_blk;
  sample_res_t sres;

  assign in_stall      = out_valid_r & out_stall;
  assign accept        = in_valid & ~in_stall;
  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  assign sample_due = sample_tmr_r <= TW'(1);
  assign blink_due  = blink_tmr_r <= TW'(1);
  assign idle       = ind_mode_r == IND_OFF;

  sccmb_sample #(
    .ADC_BITS(ADC_BITS)
  ) u_sample (
    .adc_code    (in_adc_code),
    .buf_state   (buf_state_r),
    .usb_level   (usb_r),
    .idle        (idle),
    .empty_level (empty_level_r),
    .charge_level(charge_level_r),
    .full_level  (full_level_r),
    .res         (sres)
  );

  always_comb begin
    buf_state_nxt  = buf_state_r;
    usb_nxt        = usb_r;
    sleep_nxt      = 1'b0;
    ind_mid        = ind_mode_r;
    sample_tmr_nxt = sample_tmr_r - TW'(1);
    if (sample_due) begin
      buf_state_nxt  = sres.buf_nxt;
      usb_nxt        = sres.usb_nxt;
      sleep_nxt      = sres.sleep;
      sample_tmr_nxt = reload_of(sres.sleep ? after_sleep_r : sample_per_r);
      if (sres.req && idle) begin
        ind_mid = sres.req_mode;
      end
    end
  end

  always_comb begin
    ind_blk = ind_mid;
    tog_blk = toggles_r;
    case (ind_mid)
      IND_EMPTY: begin
        tog_blk = TOG_EMPTY;
        ind_blk = IND_RUN;
      end
      IND_UP: begin
        tog_blk = TOG_UP;
        ind_blk = IND_RUN;
      end
      IND_DOWN: begin
        tog_blk = TOG_DOWN;
        ind_blk = IND_RUN;
      end
      IND_FULL: begin
        tog_blk = TOG_FULL;
        ind_blk = IND_RUN;
      end
      default: begin
      end
    endcase

    ind_mode_nxt  = ind_mid;
    toggles_nxt   = toggles_r;
    led_nxt       = led_r;
    blink_tmr_nxt = blink_tmr_r - TW'(1);
    if (blink_due) begin
      ind_mode_nxt  = ind_blk;
      toggles_nxt   = tog_blk;
      blink_tmr_nxt = reload_of(blink_step_r);
      if (ind_blk == IND_RUN && tog_blk == '0) begin
        ind_mode_nxt  = IND_OFF;
        led_nxt       = 1'b0;
        blink_tmr_nxt = reload_of(blink_pause_r);
      end else if (ind_blk == IND_RUN) begin
        toggles_nxt = tog_blk - TOG_W'(1);
        led_nxt     = ~led_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_level_r  <= EMPTY_LEVEL_RST;
      charge_level_r <= CHARGE_LEVEL_RST;
      full_level_r   <= FULL_LEVEL_RST;
      blink_step_r   <= BLINK_STEP_RST;
      blink_pause_r  <= BLINK_PAUSE_RST;
      sample_per_r   <= SAMPLE_PER_RST;
      after_sleep_r  <= AFTER_SLEEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        REG_EMPTY_LEVEL:  empty_level_r  <= cfg_data[LEVEL_W-1:0];
        REG_CHARGE_LEVEL: charge_level_r <= cfg_data[LEVEL_W-1:0];
        REG_FULL_LEVEL:   full_level_r   <= cfg_data[LEVEL_W-1:0];
        REG_BLINK_STEP:   blink_step_r   <= cfg_data[TICK_W-1:0];
        REG_BLINK_PAUSE:  blink_pause_r  <= cfg_data[TICK_W-1:0];
        REG_SAMPLE_PER:   sample_per_r   <= cfg_data[TICK_W-1:0];
        REG_AFTER_SLEEP:  after_sleep_r  <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_state_r  <= BUF_START;
      ind_mode_r   <= IND_OFF;
      toggles_r    <= '0;
      led_r        <= 1'b1;
      usb_r        <= 1'b0;
      blink_tmr_r  <= TW'(1);
      sample_tmr_r <= TW'(SAMPLE_TMR_RST);
      out_valid_r  <= 1'b0;
      sleep_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        buf_state_r  <= buf_state_nxt;
        ind_mode_r   <= ind_mode_nxt;
        toggles_r    <= toggles_nxt;
        led_r        <= led_nxt;
        usb_r        <= usb_nxt;
        blink_tmr_r  <= blink_tmr_nxt;
        sample_tmr_r <= sample_tmr_nxt;
        sleep_r      <= sleep_nxt;
      end
    end
  end

  // state only moves on an accepted beat, so it also holds the stalled result
  assign out_valid         = out_valid_r;
  assign out_led_on        = led_r;
  assign out_usb_on        = usb_r;
  assign out_sleep_request = sleep_r;
  assign out_buffer_mode   = buf_state_r;

endmodule
